// ===== rtl/preemptive_start_order_scheduler_top_defines.svh =====
// ----------------------------------------------------------------------------
// Assertion macros for the preemptive start-order scheduler
// Concurrent checks clocked on aclk and disabled while aresetn is low.
// ----------------------------------------------------------------------------
`ifndef PREEMPTIVE_START_ORDER_SCHEDULER_TOP_DEFINES_SVH
`define PREEMPTIVE_START_ORDER_SCHEDULER_TOP_DEFINES_SVH

`ifndef SYNTHESIS
`define PSOS_ASSERT(label, cond) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (cond)) \
        else $error("scheduler check failed");
`define PSOS_ASSERT_NEXT(label, trig, cond) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (trig) |=> (cond)) \
        else $error("scheduler check failed");
`else
`define PSOS_ASSERT(label, cond)
`define PSOS_ASSERT_NEXT(label, trig, cond)
`endif

`endif

// ===== rtl/psos_pkg.sv =====
// ----------------------------------------------------------------------------
// Preemptive start-order scheduler package
// Queue sizing, the queue entry layout and the result flag layout.
// ----------------------------------------------------------------------------
`default_nettype none

package psos_pkg;

    localparam int QUEUE_DEPTH = 16;
    localparam int ADDR_W      = $clog2(QUEUE_DEPTH);
    localparam int CNT_W       = $clog2(QUEUE_DEPTH + 1);

    localparam int IN_DATA_W   = 40;
    localparam int OUT_DATA_W  = 72;
    localparam int OUT_USER_W  = 4;

    typedef struct packed {
        logic [15:0] key;
        logic [7:0]  ident;
        logic [15:0] left;
    } entry_t;

    typedef struct packed {
        logic overflow;
        logic idle;
        logic finished;
        logic granted;
    } flags_t;

endpackage

`default_nettype wire

// ===== rtl/preemptive_start_order_scheduler_top.sv =====
// ----------------------------------------------------------------------------
// Preemptive start-order scheduler
// Sorted job queue held in a circular buffer memory. Arrivals are inserted
// behind all entries with an equal or smaller start; a run word grants one
// time unit to the front job and requeues it while work remains.
//
//   Channel  Direction  tdata (low bit first)                 tuser
//   s_       in         job_id, start_time, work_units        func
//   m_       out        granted_id, slot_start, compl. sum    granted, finished,
//                                                             idle, overflow
//
// An arrive word moves each queued job with a later start up one place and
// then writes the new job into the freed place; on a full queue it is dropped.
// A run word pops the front job and requeues it the same way while work
// remains, finishes it otherwise, and reports idle on an empty queue.
// Reset clears the pointers, time and total; the queue memory is not cleared.
// A word is taken whenever the block is idle, even while the last result
// waits on m_tready; the next result waits until the output register is free.
// ----------------------------------------------------------------------------
`default_nettype none
`include "preemptive_start_order_scheduler_top_defines.svh"

module preemptive_start_order_scheduler_top (
    input  wire logic                            aclk,
    input  wire logic                            aresetn,
    // tdata: job_id[7:0], start_time[23:8], work_units[39:24]
    input  wire logic [psos_pkg::IN_DATA_W-1:0]  s_tdata,
    // tuser: func[0]
    input  wire logic                            s_tuser,
    input  wire logic                            s_tvalid,
    output      logic                            s_tready,
    // tdata: granted_id[7:0], slot_start[39:8], completion_sum[71:40]
    output      logic [psos_pkg::OUT_DATA_W-1:0] m_tdata,
    // tuser: granted[0], finished[1], idle[2], overflow[3]
    output      logic [psos_pkg::OUT_USER_W-1:0] m_tuser,
    output      logic                            m_tvalid,
    input  wire logic                            m_tready
);

    import psos_pkg::*;

    typedef enum logic [4:0] {
        ST_IDLE    = 5'b00001,
        ST_POP     = 5'b00010,
        ST_INS_RD  = 5'b00100,
        ST_INS_CMP = 5'b01000,
        ST_DONE    = 5'b10000
    } state_t;

    state_t state_reg, state_next;

    entry_t mem [QUEUE_DEPTH];
    entry_t rd_data_reg;
    logic   rd_en;
    logic [ADDR_W-1:0] rd_addr;
    logic   wr_en;
    logic [ADDR_W-1:0] wr_addr;
    entry_t wr_data;

    logic [ADDR_W-1:0] head_reg, head_next;
    logic [CNT_W-1:0]  occ_reg, occ_next;
    logic [ADDR_W-1:0] pos_reg, pos_next;
    logic [31:0]       now_reg, now_next;
    logic [31:0]       sum_reg, sum_next;
    entry_t            new_reg, new_next;
    logic [7:0]        gid_reg, gid_next;
    logic [31:0]       slot_reg, slot_next;
    flags_t            flags_reg, flags_next;

    logic [OUT_DATA_W-1:0] m_tdata_reg, m_tdata_next;
    flags_t                m_tuser_reg, m_tuser_next;
    logic                  m_tvalid_reg, m_tvalid_next;

    logic        s_accept;
    logic [7:0]  in_id;
    logic [15:0] in_start;
    logic [15:0] in_work;
    logic [31:0] now_inc;
    logic [32:0] sum_ext;

    function automatic logic [ADDR_W-1:0] phys_addr(input logic [ADDR_W-1:0] head,
                                                    input logic [ADDR_W-1:0] idx);
        logic [ADDR_W:0] s;
        s = {1'b0, head} + {1'b0, idx};
        if (s >= (ADDR_W + 1)'(QUEUE_DEPTH)) begin
            s = s - (ADDR_W + 1)'(QUEUE_DEPTH);
        end
        return s[ADDR_W-1:0];
    endfunction

    assign s_tready = (state_reg == ST_IDLE);
    assign s_accept = s_tvalid && s_tready;
    assign in_id    = s_tdata[7:0];
    assign in_start = s_tdata[23:8];
    assign in_work  = s_tdata[39:24];
    assign now_inc  = now_reg + 32'd1;
    assign sum_ext  = {1'b0, sum_reg} + {1'b0, now_inc};

    assign m_tdata  = m_tdata_reg;
    assign m_tuser  = m_tuser_reg;
    assign m_tvalid = m_tvalid_reg;

    always_comb begin
        state_next    = state_reg;
        head_next     = head_reg;
        occ_next      = occ_reg;
        pos_next      = pos_reg;
        now_next      = now_reg;
        sum_next      = sum_reg;
        new_next      = new_reg;
        gid_next      = gid_reg;
        slot_next     = slot_reg;
        flags_next    = flags_reg;
        m_tdata_next  = m_tdata_reg;
        m_tuser_next  = m_tuser_reg;
        m_tvalid_next = m_tvalid_reg && !m_tready;
        rd_en         = 1'b0;
        rd_addr       = head_reg;
        wr_en         = 1'b0;
        wr_addr       = head_reg;
        wr_data       = new_reg;

        case (state_reg)
            ST_IDLE: begin
                if (s_accept) begin
                    slot_next  = now_reg;
                    gid_next   = 8'd0;
                    flags_next = '0;
                    if (!s_tuser) begin
                        if (occ_reg == CNT_W'(QUEUE_DEPTH)) begin
                            flags_next.overflow = 1'b1;
                            state_next          = ST_DONE;
                        end else begin
                            if (occ_reg == '0 && {16'd0, in_start} > now_reg) begin
                                now_next = {16'd0, in_start};
                            end
                            new_next.key   = in_start;
                            new_next.ident = in_id;
                            new_next.left  = (in_work == 16'd0) ? 16'd1 : in_work;
                            pos_next       = occ_reg[ADDR_W-1:0];
                            state_next     = ST_INS_RD;
                        end
                    end else begin
                        if (occ_reg == '0) begin
                            flags_next.idle = 1'b1;
                            state_next      = ST_DONE;
                        end else begin
                            rd_en      = 1'b1;
                            rd_addr    = head_reg;
                            state_next = ST_POP;
                        end
                    end
                end
            end
            ST_POP: begin
                gid_next           = rd_data_reg.ident;
                flags_next.granted = 1'b1;
                now_next           = now_inc;
                head_next          = phys_addr(head_reg, ADDR_W'(1));
                occ_next           = occ_reg - CNT_W'(1);
                if (rd_data_reg.left > 16'd1) begin
                    new_next.key   = rd_data_reg.key;
                    new_next.ident = rd_data_reg.ident;
                    new_next.left  = rd_data_reg.left - 16'd1;
                    pos_next       = occ_next[ADDR_W-1:0];
                    state_next     = ST_INS_RD;
                end else begin
                    flags_next.finished = 1'b1;
                    sum_next            = sum_ext[32] ? 32'hFFFF_FFFF : sum_ext[31:0];
                    state_next          = ST_DONE;
                end
            end
            ST_INS_RD: begin
                if (pos_reg == '0) begin
                    wr_en      = 1'b1;
                    wr_addr    = head_reg;
                    wr_data    = new_reg;
                    occ_next   = occ_reg + CNT_W'(1);
                    state_next = ST_DONE;
                end else begin
                    rd_en      = 1'b1;
                    rd_addr    = phys_addr(head_reg, pos_reg - ADDR_W'(1));
                    state_next = ST_INS_CMP;
                end
            end
            ST_INS_CMP: begin
                wr_en   = 1'b1;
                wr_addr = phys_addr(head_reg, pos_reg);
                if (rd_data_reg.key > new_reg.key) begin
                    wr_data    = rd_data_reg;
                    pos_next   = pos_reg - ADDR_W'(1);
                    state_next = ST_INS_RD;
                end else begin
                    wr_data    = new_reg;
                    occ_next   = occ_reg + CNT_W'(1);
                    state_next = ST_DONE;
                end
            end
            ST_DONE: begin
                if (!m_tvalid_reg || m_tready) begin
                    m_tdata_next  = {sum_reg, slot_reg, gid_reg};
                    m_tuser_next  = flags_reg;
                    m_tvalid_next = 1'b1;
                    state_next    = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en) begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg    <= ST_IDLE;
            head_reg     <= '0;
            occ_reg      <= '0;
            now_reg      <= '0;
            sum_reg      <= '0;
            m_tvalid_reg <= 1'b0;
        end else begin
            state_reg    <= state_next;
            head_reg     <= head_next;
            occ_reg      <= occ_next;
            now_reg      <= now_next;
            sum_reg      <= sum_next;
            m_tvalid_reg <= m_tvalid_next;
        end
    end

    always_ff @(posedge aclk) begin
        pos_reg     <= pos_next;
        new_reg     <= new_next;
        gid_reg     <= gid_next;
        slot_reg    <= slot_next;
        flags_reg   <= flags_next;
        m_tdata_reg <= m_tdata_next;
        m_tuser_reg <= m_tuser_next;
    end

    `PSOS_ASSERT(a_occ_bound, occ_reg <= CNT_W'(QUEUE_DEPTH))
    `PSOS_ASSERT_NEXT(a_accept_leaves_idle, s_accept, state_reg != ST_IDLE)
    `PSOS_ASSERT(a_insert_room, (state_reg != ST_INS_RD && state_reg != ST_INS_CMP) || (occ_reg < CNT_W'(QUEUE_DEPTH) && {1'b0, pos_reg} <= occ_reg))
    `PSOS_ASSERT(a_flags_exclusive, !m_tvalid_reg || $countones({m_tuser_reg.granted, m_tuser_reg.idle, m_tuser_reg.overflow}) <= 1)
    `PSOS_ASSERT(a_finish_needs_grant, !(m_tvalid_reg && m_tuser_reg.finished) || m_tuser_reg.granted)

endmodule

`default_nettype wire

// ===== bench/tb_preemptive_start_order_scheduler_top.sv =====
// ----------------------------------------------------------------------------
// Testbench for the preemptive start-order scheduler
// Sends arrive and run words with random gaps and random result back-pressure.
// A scoreboard keeps its own sorted job queue, time and completion total,
// predicts one result word per input word and compares every field.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module tb_preemptive_start_order_scheduler_top;

    import psos_pkg::*;

    localparam int RANDOM_WORDS = 430;
    localparam int CYCLE_LIMIT  = 300000;

    typedef enum logic {
        OP_ARRIVE = 1'b0,
        OP_RUN    = 1'b1
    } op_e;

    typedef struct packed {
        logic [7:0]  granted_id;
        logic [31:0] slot_start;
        logic [31:0] completion_sum;
        flags_t      flags;
    } sched_result_t;

    class sched_scoreboard;
        entry_t        slots[QUEUE_DEPTH];
        int unsigned   occ;
        logic [31:0]   now_t;
        logic [31:0]   total;
        sched_result_t awaited[$];
        int            errors;

        function new();
            occ    = 0;
            now_t  = '0;
            total  = '0;
            errors = 0;
        endfunction

        function void enqueue_by_start(entry_t e);
            int unsigned pos;
            pos = occ;
            while (pos > 0 && slots[pos-1].key > e.key) begin
                slots[pos] = slots[pos-1];
                pos--;
            end
            slots[pos] = e;
            occ++;
        endfunction

        function void note_word(op_e op, logic [7:0] id, logic [15:0] start,
                                logic [15:0] work);
            sched_result_t r;
            entry_t        e;
            logic [32:0]   acc;
            r = '0;
            r.slot_start = now_t;
            if (op == OP_ARRIVE) begin
                if (occ >= QUEUE_DEPTH) begin
                    r.flags.overflow = 1'b1;
                end else begin
                    if (occ == 0 && {16'd0, start} > now_t) begin
                        now_t = {16'd0, start};
                    end
                    e.key   = start;
                    e.ident = id;
                    e.left  = (work == 16'd0) ? 16'd1 : work;
                    enqueue_by_start(e);
                end
            end else if (occ == 0) begin
                r.flags.idle = 1'b1;
            end else begin
                e = slots[0];
                for (int i = 1; i < occ; i++) begin
                    slots[i-1] = slots[i];
                end
                occ--;
                now_t = now_t + 32'd1;
                r.granted_id    = e.ident;
                r.flags.granted = 1'b1;
                if (e.left > 16'd1) begin
                    e.left = e.left - 16'd1;
                    enqueue_by_start(e);
                end else begin
                    r.flags.finished = 1'b1;
                    acc   = {1'b0, total} + {1'b0, now_t};
                    total = acc[32] ? 32'hFFFF_FFFF : acc[31:0];
                end
            end
            r.completion_sum = total;
            awaited.push_back(r);
        endfunction

        function void compare(string name, logic [31:0] want, logic [31:0] got);
            if (got !== want) begin
                errors++;
                $display("%0t: %s mismatch, expected %h, actual %h", $time, name, want, got);
            end
        endfunction

        function void check_result(logic [OUT_DATA_W-1:0] d, flags_t u);
            sched_result_t want;
            if (awaited.size() == 0) begin
                errors++;
                $display("%0t: unexpected result word, expected none, actual %h / %h",
                         $time, d, u);
                return;
            end
            want = awaited.pop_front();
            compare("granted_id", 32'(want.granted_id), 32'(d[7:0]));
            compare("slot_start", want.slot_start, d[39:8]);
            compare("completion_sum", want.completion_sum, d[71:40]);
            compare("granted", 32'(want.flags.granted), 32'(u.granted));
            compare("finished", 32'(want.flags.finished), 32'(u.finished));
            compare("idle", 32'(want.flags.idle), 32'(u.idle));
            compare("overflow", 32'(want.flags.overflow), 32'(u.overflow));
        endfunction
    endclass

    logic                  aclk;
    logic                  aresetn;
    logic [IN_DATA_W-1:0]  s_tdata;
    logic                  s_tuser;
    logic                  s_tvalid;
    logic                  s_tready;
    logic [OUT_DATA_W-1:0] m_tdata;
    logic [OUT_USER_W-1:0] m_tuser;
    logic                  m_tvalid;
    logic                  m_tready;

    bit              calm = 1'b0;
    int unsigned     cycles = 0;
    sched_scoreboard sb = new();

    preemptive_start_order_scheduler_top DUT (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready)
    );

    initial begin
        aclk = 1'b0;
        forever #5 aclk = ~aclk;
    end

    always @(posedge aclk) begin
        cycles <= cycles + 1;
        if (cycles >= CYCLE_LIMIT) begin
            $display("Testbench completed WITH ERRORS");
            $finish;
        end
    end

    always @(posedge aclk) begin
        if (aresetn && m_tvalid && m_tready) begin
            sb.check_result(m_tdata, flags_t'(m_tuser));
        end
    end

    initial begin
        m_tready = 1'b0;
        forever begin
            @(negedge aclk);
            m_tready <= calm || ($urandom_range(99) >= 37);
        end
    end

    task automatic send_word(op_e op, logic [7:0] id, logic [15:0] start,
                             logic [15:0] work);
        while (!calm && $urandom_range(99) < 37) begin
            s_tvalid <= 1'b0;
            @(negedge aclk);
        end
        s_tdata  <= {work, start, id};
        s_tuser  <= op;
        s_tvalid <= 1'b1;
        do @(posedge aclk); while (!s_tready);
        sb.note_word(op, id, start, work);
        @(negedge aclk);
    endtask

    initial begin
        bit          fill_mode;
        bit          big;
        int unsigned next_switch;
        int unsigned now_i;
        int unsigned hi;
        int unsigned lo;
        logic [15:0] start;
        logic [15:0] work;

        aresetn  = 1'b0;
        s_tdata  = '0;
        s_tuser  = 1'b0;
        s_tvalid = 1'b0;
        repeat (4) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;
        @(negedge aclk);

        // Idle run, zero work, then a jump of the time on an empty queue.
        send_word(OP_RUN, 8'h00, 16'h0000, 16'h0000);
        send_word(OP_ARRIVE, 8'hFF, 16'h0000, 16'h0000);
        send_word(OP_RUN, 8'h00, 16'h0000, 16'h0000);
        send_word(OP_ARRIVE, 8'h01, 16'h1234, 16'h0002);
        // Equal start keeps arrival order, an earlier start goes to the front,
        // and a future start on a busy queue leaves the time alone.
        send_word(OP_ARRIVE, 8'h02, 16'h1234, 16'h0001);
        send_word(OP_ARRIVE, 8'h03, 16'h1000, 16'h0001);
        send_word(OP_ARRIVE, 8'h04, 16'hFFFF, 16'h0001);
        for (int i = 0; i < 12; i++) begin
            send_word(OP_ARRIVE, 8'(16 + i), 16'(16'h1100 + i * 16), 16'(i % 3 + 1));
        end
        send_word(OP_ARRIVE, 8'hAA, 16'h1200, 16'h0003);
        send_word(OP_RUN, 8'h00, 16'h0000, 16'h0000);
        send_word(OP_RUN, 8'h00, 16'h0000, 16'h0000);

        fill_mode   = 1'b0;
        next_switch = 0;
        for (int n = 0; n < RANDOM_WORDS; n++) begin
            if (n == next_switch) begin
                fill_mode   = !fill_mode;
                next_switch = n + $urandom_range(45, 15);
            end
            calm = (n >= 150 && n < 230);
            big  = (n == 380) || (n > 300 && $urandom_range(99) < 2);
            if (big || $urandom_range(99) < (fill_mode ? 75 : 25)) begin
                now_i = sb.now_t;
                if (big) begin
                    work  = 16'h8000 | 16'($urandom_range(65535));
                    start = 16'hFFFF;
                end else begin
                    if ($urandom_range(99) < 85) begin
                        work = 16'($urandom_range(4));
                    end else begin
                        work = 16'($urandom_range(40));
                    end
                    if (sb.occ == 0 && now_i < 65535 && $urandom_range(99) < 60) begin
                        hi    = (now_i + 3000 > 65535) ? 65535 : now_i + 3000;
                        start = 16'($urandom_range(hi, now_i + 1));
                    end else if (sb.occ != 0 && now_i < 65535 && $urandom_range(99) < 6) begin
                        start = 16'($urandom_range(65535, now_i + 1));
                    end else begin
                        hi    = (now_i > 65535) ? 65535 : now_i;
                        lo    = (hi > 200) ? hi - 200 : 0;
                        start = 16'($urandom_range(hi, lo));
                    end
                end
                send_word(OP_ARRIVE, 8'($urandom_range(255)), start, work);
            end else begin
                send_word(OP_RUN, 8'($urandom), 16'($urandom), 16'($urandom));
            end
        end
        calm = 1'b0;
        s_tvalid <= 1'b0;

        while (sb.awaited.size() != 0) @(posedge aclk);
        repeat (40) @(posedge aclk);
        if (sb.errors == 0) begin
            $display("Testbench completed without errors");
        end else begin
            $display("Testbench completed WITH ERRORS");
        end
        $finish;
    end

endmodule
